FILE: rtl/sgst_pkg.sv
// Shared constants and field widths for the spatial grid slot table.
`timescale 1ns / 1ps

package sgst_pkg;

  // Default geometry
  localparam int GRID_DIM_DEF = 16;
  localparam int SLOTS_DEF    = 16;

  // Field widths
  localparam int POS_W    = 16;
  localparam int COLOR_W  = 4;
  localparam int IDX_W    = 4;
  localparam int STATUS_W = 3;
  localparam int OCC_W    = 5;
  localparam int MAP_W    = 16;

  // A clamped coordinate is never negative, so 15 bits hold it
  localparam int CELL_W = POS_W - 1;

  localparam logic [MAP_W-1:0] MAP_SIZE_RESET = 16'd4096;

  // Commands
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_STORED  = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_OUTSIDE = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL    = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_REMOVED = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_EMPTY   = 3'd4;

  // Request held while an item is processed
  typedef struct packed {
    logic               cmd;
    logic [COLOR_W-1:0] color;
    logic [CELL_W-1:0]  pos_x;
    logic [CELL_W-1:0]  pos_y;
    logic [IDX_W-1:0]   bucket_x;
    logic [IDX_W-1:0]   bucket_y;
    logic [IDX_W-1:0]   slot;
  } req_t;

endpackage

FILE: rtl/sgst_if.sv
// Valid/ready channel interfaces for commands and results.
`timescale 1ns / 1ps

interface sgst_in_if;
  import sgst_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      command;
  logic signed [POS_W-1:0]   pos_x;
  logic signed [POS_W-1:0]   pos_y;
  logic        [COLOR_W-1:0] color;
  logic        [IDX_W-1:0]   bucket_x;
  logic        [IDX_W-1:0]   bucket_y;
  logic        [IDX_W-1:0]   slot;

  modport source (output valid, command, pos_x, pos_y, color, bucket_x, bucket_y, slot,
                  input ready);
  modport sink   (input valid, command, pos_x, pos_y, color, bucket_x, bucket_y, slot,
                  output ready);
endinterface

interface sgst_out_if;
  import sgst_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [IDX_W-1:0]    out_bucket_x;
  logic [IDX_W-1:0]    out_bucket_y;
  logic [IDX_W-1:0]    out_slot;
  logic [OCC_W-1:0]    occupancy;

  modport source (output valid, status, out_bucket_x, out_bucket_y, out_slot, occupancy,
                  input ready);
  modport sink   (input valid, status, out_bucket_x, out_bucket_y, out_slot, occupancy,
                  output ready);
endinterface

FILE: rtl/sgst_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module sgst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; data holds when no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/sgst_coord_div.sv
// Divides a clamped coordinate by the grid dimension with a reciprocal multiply.
`timescale 1ns / 1ps

module sgst_coord_div #(
  parameter int GRID_DIM = sgst_pkg::GRID_DIM_DEF
) (
  input  logic [sgst_pkg::CELL_W-1:0] coord,
  output logic [sgst_pkg::CELL_W-1:0] quot
);
  import sgst_pkg::*;

  // q = (v * ceil(2^S / D)) >> S is exact for v < 2^CELL_W when S = CELL_W + clog2(D)
  localparam int              SHIFT   = CELL_W + $clog2(GRID_DIM);
  localparam longint unsigned RECIP   = ((64'd1 << SHIFT) + GRID_DIM - 1) / GRID_DIM;
  localparam int              RECIP_W = CELL_W + 2;
  localparam int              PROD_W  = SHIFT + CELL_W;

  logic [PROD_W-1:0] prod;

  assign prod = PROD_W'(coord) * PROD_W'(RECIP_W'(RECIP));
  assign quot = prod[SHIFT +: CELL_W];

endmodule

FILE: rtl/spatial_grid_slot_table.sv
// Top level: grid bucket table with read-modify-write of one bucket word per item.
// The result is registered after the locate, read and update steps.
// A new item is accepted only after the bucket memory read-modify-write of the last one completes.
// A held result stalls the update step, and no new item is accepted until it completes.
// Reset (synchronous, active high) starts a clearing pass over all 4**clog2(GRID_DIM)
// words of the bucket memory (256 at default size); no item is accepted until it ends.
`timescale 1ns / 1ps

module spatial_grid_slot_table #(
  parameter int GRID_DIM = sgst_pkg::GRID_DIM_DEF,
  parameter int SLOTS    = sgst_pkg::SLOTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [sgst_pkg::MAP_W-1:0] cfg_wr_data,
  sgst_in_if.sink                    in_ch,
  sgst_out_if.source                 out_ch
);
  import sgst_pkg::*;

  localparam int CW     = $clog2(GRID_DIM);
  localparam int AW     = 2 * CW;
  localparam int DEPTH  = 1 << AW;
  localparam int CNTW   = $clog2(SLOTS + 1);
  localparam int WORD_W = SLOTS + CNTW;

  typedef enum logic [3:0] {
    SM_CLEAR  = 4'b0001,
    SM_IDLE   = 4'b0010,
    SM_CALC   = 4'b0100,
    SM_UPDATE = 4'b1000
  } state_t;

  state_t            state;
  logic [AW-1:0]     clr_addr;
  logic [MAP_W-1:0]  map_size;
  req_t              req;
  logic [CELL_W-1:0] cur_bx;
  logic [CELL_W-1:0] cur_by;
  logic              cur_in_grid;
  logic [AW-1:0]     cur_addr;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      map_size <= MAP_SIZE_RESET;
    end else if (cfg_wr_en) begin
      map_size <= cfg_wr_data;
    end
  end

  // Clamp coordinates to the map on accept
  logic [MAP_W-1:0]  top;
  logic [CELL_W-1:0] clamp_x;
  logic [CELL_W-1:0] clamp_y;
  logic              accept;

  assign top    = (map_size == '0) ? '0 : map_size - MAP_W'(1);
  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == SM_IDLE);

  always_comb begin
    if (in_ch.pos_x[POS_W-1]) begin
      clamp_x = '0;
    end else if ({1'b0, in_ch.pos_x[CELL_W-1:0]} > top) begin
      clamp_x = top[CELL_W-1:0];
    end else begin
      clamp_x = in_ch.pos_x[CELL_W-1:0];
    end
    if (in_ch.pos_y[POS_W-1]) begin
      clamp_y = '0;
    end else if ({1'b0, in_ch.pos_y[CELL_W-1:0]} > top) begin
      clamp_y = top[CELL_W-1:0];
    end else begin
      clamp_y = in_ch.pos_y[CELL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req.cmd      <= in_ch.command;
      req.color    <= in_ch.color;
      req.pos_x    <= clamp_x;
      req.pos_y    <= clamp_y;
      req.bucket_x <= in_ch.bucket_x;
      req.bucket_y <= in_ch.bucket_y;
      req.slot     <= in_ch.slot;
    end
  end

  // Bucket lookup: divide for insert, direct index for remove
  logic [CELL_W-1:0] qx;
  logic [CELL_W-1:0] qy;
  logic [CELL_W-1:0] sel_bx;
  logic [CELL_W-1:0] sel_by;
  logic              sel_in_grid;
  logic [AW-1:0]     sel_addr;

  sgst_coord_div #(.GRID_DIM(GRID_DIM)) u_div_x (.coord(req.pos_x), .quot(qx));
  sgst_coord_div #(.GRID_DIM(GRID_DIM)) u_div_y (.coord(req.pos_y), .quot(qy));

  assign sel_bx      = (req.cmd == CMD_REMOVE) ? CELL_W'(req.bucket_x) : qx;
  assign sel_by      = (req.cmd == CMD_REMOVE) ? CELL_W'(req.bucket_y) : qy;
  assign sel_in_grid = (sel_bx < CELL_W'(GRID_DIM)) && (sel_by < CELL_W'(GRID_DIM));
  assign sel_addr    = {sel_by[CW-1:0], sel_bx[CW-1:0]};

  always_ff @(posedge clk) begin
    if (state == SM_CALC) begin
      cur_bx      <= sel_bx;
      cur_by      <= sel_by;
      cur_in_grid <= sel_in_grid;
      cur_addr    <= sel_addr;
    end
  end

  // Bucket memory: occupancy mask in the low bits, point count above it
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;

  sgst_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_bucket_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (state == SM_CALC),
    .rd_addr (sel_addr),
    .rd_data (ram_rdata)
  );

  // Update of the bucket word and the result
  logic [SLOTS-1:0]    mask;
  logic [CNTW-1:0]     count;
  logic [SLOTS-1:0]    free_oh;
  logic [SLOTS-1:0]    slot_oh;
  logic [IDX_W-1:0]    free_idx;
  logic                upd_write;
  logic [SLOTS-1:0]    mask_next;
  logic [CNTW-1:0]     count_next;
  logic [STATUS_W-1:0] res_status;
  logic [IDX_W-1:0]    res_bx;
  logic [IDX_W-1:0]    res_by;
  logic [IDX_W-1:0]    res_slot;
  logic [OCC_W-1:0]    res_occ;
  logic                out_free;

  assign mask    = ram_rdata[SLOTS-1:0];
  assign count   = ram_rdata[WORD_W-1:SLOTS];
  assign free_oh = ~mask & (mask + SLOTS'(1));

  always_comb begin
    free_idx = '0;
    slot_oh  = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (free_oh[i]) begin
        free_idx = free_idx | IDX_W'(i);
      end
      slot_oh[i] = (int'(req.slot) == i);
    end
  end

  always_comb begin
    upd_write  = 1'b0;
    mask_next  = mask;
    count_next = count;
    res_bx     = cur_bx[IDX_W-1:0];
    res_by     = cur_by[IDX_W-1:0];
    res_slot   = '0;
    res_occ    = OCC_W'(count);
    res_status = STAT_STORED;
    if (req.cmd == CMD_INSERT) begin
      if (!cur_in_grid) begin
        res_status = STAT_OUTSIDE;
        res_bx     = '0;
        res_by     = '0;
        res_occ    = '0;
      end else if (&mask) begin
        res_status = STAT_FULL;
      end else begin
        res_slot = free_idx;
        if (req.color != '0) begin
          upd_write  = 1'b1;
          mask_next  = mask | free_oh;
          count_next = count + CNTW'(1);
          res_occ    = OCC_W'(count + CNTW'(1));
        end
      end
    end else begin
      res_slot = req.slot;
      if (!cur_in_grid) begin
        res_status = STAT_OUTSIDE;
        res_occ    = '0;
      end else if (!(|(mask & slot_oh))) begin
        res_status = STAT_EMPTY;
      end else begin
        upd_write  = 1'b1;
        res_status = STAT_REMOVED;
        mask_next  = mask & ~slot_oh;
        if (count != '0) begin
          count_next = count - CNTW'(1);
          res_occ    = OCC_W'(count - CNTW'(1));
        end
      end
    end
  end

  // Write port: clearing pass or write-back of the updated bucket
  assign out_free  = !out_ch.valid || out_ch.ready;
  assign ram_we    = (state == SM_CLEAR) || ((state == SM_UPDATE) && out_free && upd_write);
  assign ram_waddr = (state == SM_CLEAR) ? clr_addr : cur_addr;
  assign ram_wdata = (state == SM_CLEAR) ? '0 : {count_next, mask_next};

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= SM_CLEAR;
      clr_addr <= '0;
    end else begin
      unique case (state)
        SM_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (&clr_addr) begin
            state <= SM_IDLE;
          end
        end
        SM_IDLE: begin
          if (accept) begin
            state <= SM_CALC;
          end
        end
        SM_CALC: begin
          state <= SM_UPDATE;
        end
        SM_UPDATE: begin
          if (out_free) begin
            state <= SM_IDLE;
          end
        end
        default: begin
          state <= SM_CLEAR;
        end
      endcase
    end
  end

  // Output register
  logic load_out;
  assign load_out = (state == SM_UPDATE) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (load_out) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_ch.status       <= res_status;
      out_ch.out_bucket_x <= res_bx;
      out_ch.out_bucket_y <= res_by;
      out_ch.out_slot     <= res_slot;
      out_ch.occupancy    <= res_occ;
    end
  end

endmodule

FILE: sim/spatial_grid_slot_table_tb.sv
// Self-checking testbench for the spatial grid slot table: directed and random item traffic.
`timescale 1ns / 1ps

module spatial_grid_slot_table_tb;
  import sgst_pkg::*;

  localparam int GRID_DIM   = GRID_DIM_DEF;
  localparam int SLOTS      = SLOTS_DEF;
  localparam int BUCKETS    = GRID_DIM * GRID_DIM;
  localparam int DRAIN_PAD  = 8;
  localparam int CYCLE_CAP  = 400000;
  localparam int IDLE_PCT   = 37;

  // One command item and one result item
  typedef struct {
    logic                     command;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic [COLOR_W-1:0]       color;
    logic [IDX_W-1:0]         bucket_x;
    logic [IDX_W-1:0]         bucket_y;
    logic [IDX_W-1:0]         slot;
  } grid_cmd_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    bucket_x;
    logic [IDX_W-1:0]    bucket_y;
    logic [IDX_W-1:0]    slot;
    logic [OCC_W-1:0]    occupancy;
  } grid_result_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [MAP_W-1:0] cfg_wr_data;

  sgst_in_if  in_ch ();
  sgst_out_if out_ch ();

  spatial_grid_slot_table dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  // Predictor state: slot colors, bucket counts, map extent
  logic [COLOR_W-1:0] slot_color [BUCKETS][SLOTS];
  logic [OCC_W-1:0]   bucket_fill [BUCKETS];
  logic [MAP_W-1:0]   map_extent;

  grid_result_t pending_results [$];
  int err_count;
  int cycle_count;
  bit no_stall;

  // Clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Run limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result-side ready, random stalls unless a steady stretch is on
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready = no_stall || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Table update: applies one command to the model and returns its result
  function automatic grid_result_t grid_table_update(input grid_cmd_t c);
    grid_result_t r;
    int top, px, py, cx, cy, b, s;
    r = '{default: '0};
    if (c.command == CMD_INSERT) begin
      top = (map_extent == '0) ? 0 : int'(map_extent) - 1;
      px = c.pos_x;
      py = c.pos_y;
      if (px < 0) px = 0;
      if (px > top) px = top;
      if (py < 0) py = 0;
      if (py > top) py = top;
      cx = px / GRID_DIM;
      cy = py / GRID_DIM;
      if (cx >= GRID_DIM || cy >= GRID_DIM) begin
        r.status = STAT_OUTSIDE;
        return r;
      end
      b = cy * GRID_DIM + cx;
      s = 0;
      while (s < SLOTS && slot_color[b][s] != '0) s++;
      r.bucket_x = IDX_W'(cx);
      r.bucket_y = IDX_W'(cy);
      if (s >= SLOTS) begin
        r.status    = STAT_FULL;
        r.occupancy = bucket_fill[b];
        return r;
      end
      // color zero finds a slot but writes nothing
      if (c.color != '0) begin
        slot_color[b][s] = c.color;
        bucket_fill[b]   = bucket_fill[b] + 1'b1;
      end
      r.status    = STAT_STORED;
      r.slot      = IDX_W'(s);
      r.occupancy = bucket_fill[b];
    end else begin
      r.bucket_x = c.bucket_x;
      r.bucket_y = c.bucket_y;
      r.slot     = c.slot;
      if (int'(c.bucket_x) >= GRID_DIM || int'(c.bucket_y) >= GRID_DIM) begin
        r.status = STAT_OUTSIDE;
        return r;
      end
      b = int'(c.bucket_y) * GRID_DIM + int'(c.bucket_x);
      if (int'(c.slot) >= SLOTS || slot_color[b][c.slot] == '0) begin
        r.status    = STAT_EMPTY;
        r.occupancy = bucket_fill[b];
        return r;
      end
      slot_color[b][c.slot] = '0;
      if (bucket_fill[b] != '0) bucket_fill[b] = bucket_fill[b] - 1'b1;
      r.status    = STAT_REMOVED;
      r.occupancy = bucket_fill[b];
    end
    return r;
  endfunction

  // Item builders; fields the command ignores carry random values
  function automatic grid_cmd_t insert_cmd(input int x, input int y, input int col);
    grid_cmd_t c;
    c.command  = CMD_INSERT;
    c.pos_x    = POS_W'(x);
    c.pos_y    = POS_W'(y);
    c.color    = COLOR_W'(col);
    c.bucket_x = IDX_W'($urandom);
    c.bucket_y = IDX_W'($urandom);
    c.slot     = IDX_W'($urandom);
    return c;
  endfunction

  function automatic grid_cmd_t remove_cmd(input int bx, input int by, input int sl);
    grid_cmd_t c;
    c.command  = CMD_REMOVE;
    c.pos_x    = POS_W'($urandom);
    c.pos_y    = POS_W'($urandom);
    c.color    = COLOR_W'($urandom);
    c.bucket_x = IDX_W'(bx);
    c.bucket_y = IDX_W'(by);
    c.slot     = IDX_W'(sl);
    return c;
  endfunction

  // Random item biased toward a few hot buckets so they fill and empty
  function automatic int hot_index();
    return ($urandom_range(99) < 75) ? $urandom_range(2) : $urandom_range(GRID_DIM - 1);
  endfunction

  function automatic grid_cmd_t random_cmd();
    int sel;
    sel = $urandom_range(99);
    if (sel < 40)
      return insert_cmd(hot_index() * GRID_DIM + $urandom_range(GRID_DIM - 1),
                        hot_index() * GRID_DIM + $urandom_range(GRID_DIM - 1),
                        $urandom_range(15));
    if (sel < 58)
      return insert_cmd($urandom_range(65535), $urandom_range(65535), $urandom_range(15));
    return remove_cmd(hot_index(), hot_index(), $urandom_range(SLOTS - 1));
  endfunction

  // Send one item; entered and left at a falling edge
  task automatic send_cmd(input grid_cmd_t c);
    if (!no_stall && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    in_ch.command  = c.command;
    in_ch.pos_x    = c.pos_x;
    in_ch.pos_y    = c.pos_y;
    in_ch.color    = c.color;
    in_ch.bucket_x = c.bucket_x;
    in_ch.bucket_y = c.bucket_y;
    in_ch.slot     = c.slot;
    in_ch.valid    = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(grid_table_update(c));
    @(negedge clk);
  endtask

  // Hold off input until every pending result has come out
  task automatic drain_results();
    in_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
    @(negedge clk);
  endtask

  // Map size write, only with the block idle
  task automatic set_map_size(input logic [MAP_W-1:0] value);
    drain_results();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    map_extent  = value;
  endtask

  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      err_count++;
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    grid_result_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result item with nothing pending");
        err_count++;
      end else begin
        e = pending_results.pop_front();
        check_field("status", e.status, out_ch.status);
        check_field("out_bucket_x", e.bucket_x, out_ch.out_bucket_x);
        check_field("out_bucket_y", e.bucket_y, out_ch.out_bucket_y);
        check_field("out_slot", e.slot, out_ch.out_slot);
        check_field("occupancy", e.occupancy, out_ch.occupancy);
      end
    end
  end

  // Reset-value map: clamping of negatives, grid edge, color zero, remove hit and miss
  task automatic test_default_map();
    send_cmd(insert_cmd(-32768, -1, 1));
    send_cmd(insert_cmd(255, 255, 15));
    send_cmd(insert_cmd(256, 0, 4));
    send_cmd(insert_cmd(32767, 32767, 6));
    send_cmd(insert_cmd(3, 7, 0));
    send_cmd(remove_cmd(0, 0, 0));
    send_cmd(remove_cmd(0, 0, 0));
    send_cmd(remove_cmd(15, 15, 15));
    drain_results();
  endtask

  // Fill one bucket, overflow it, then free and reuse a slot
  task automatic test_full_bucket();
    for (int i = 0; i < SLOTS; i++)
      send_cmd(insert_cmd(3 * GRID_DIM + i, 4 * GRID_DIM + 15 - i, 1 + (i % 15)));
    send_cmd(insert_cmd(3 * GRID_DIM, 4 * GRID_DIM, 9));
    send_cmd(insert_cmd(3 * GRID_DIM + 5, 4 * GRID_DIM + 5, 0));
    send_cmd(remove_cmd(3, 4, 7));
    send_cmd(insert_cmd(3 * GRID_DIM + 1, 4 * GRID_DIM + 1, 12));
    drain_results();
  endtask

  // Map size zero, one and the largest
  task automatic test_map_extremes();
    set_map_size('0);
    send_cmd(insert_cmd(1000, -5, 9));
    send_cmd(insert_cmd(-32768, 32767, 3));
    set_map_size(16'd1);
    send_cmd(insert_cmd(5, 5, 0));
    set_map_size(16'hFFFF);
    send_cmd(insert_cmd(32767, 32767, 7));
    send_cmd(insert_cmd(4095, -1, 2));
    drain_results();
  endtask

  // Random traffic under one map size, with a full drain halfway through
  task automatic test_random_traffic(input logic [MAP_W-1:0] size, input int count,
                                     input bit steady);
    set_map_size(size);
    no_stall = steady;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) drain_results();
      send_cmd(random_cmd());
    end
    drain_results();
    no_stall = 1'b0;
  endtask

  // Sequence
  initial begin
    err_count      = 0;
    no_stall       = 1'b0;
    rst            = 1'b1;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    in_ch.valid    = 1'b0;
    in_ch.command  = CMD_INSERT;
    in_ch.pos_x    = '0;
    in_ch.pos_y    = '0;
    in_ch.color    = '0;
    in_ch.bucket_x = '0;
    in_ch.bucket_y = '0;
    in_ch.slot     = '0;
    map_extent     = MAP_SIZE_RESET;
    for (int b = 0; b < BUCKETS; b++) begin
      bucket_fill[b] = '0;
      for (int s = 0; s < SLOTS; s++) slot_color[b][s] = '0;
    end
    repeat (6) @(negedge clk);
    rst = 1'b0;

    test_default_map();
    test_full_bucket();
    test_map_extremes();
    test_random_traffic(16'd4096, 300, 1'b0);
    test_random_traffic(16'd1, 150, 1'b0);
    test_random_traffic(16'd0, 100, 1'b0);
    test_random_traffic(16'hFFFF, 250, 1'b0);
    test_random_traffic(16'd256, 300, 1'b1);
    test_random_traffic(16'd255, 250, 1'b0);
    test_random_traffic(MAP_W'($urandom_range(65535, 1)), 250, 1'b0);
    test_random_traffic(16'd4096, 250, 1'b0);

    drain_results();
    if (pending_results.size() != 0) begin
      $error("%0d result items never arrived", pending_results.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: spatial_grid_slot_table.f
rtl/sgst_pkg.sv
rtl/sgst_if.sv
rtl/sgst_ram.sv
rtl/sgst_coord_div.sv
rtl/spatial_grid_slot_table.sv
sim/spatial_grid_slot_table_tb.sv
